// ===== rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // Channel payloads
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] saturation;
        logic [6:0] brightness;
    } hsv_t;

    // Which channel holds the maximum (ties go red, then green)
    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    localparam int DVD_W = 15;   // dividend: up to 100*255
    localparam int DVS_W = 8;    // divisor: diff or max
    localparam int QUO_W = 8;    // quotient bits, one per division step

    localparam logic [8:0] RED_BASE   = 9'd360;
    localparam logic [8:0] GREEN_BASE = 9'd120;
    localparam logic [8:0] BLUE_BASE  = 9'd240;
    localparam logic [8:0] TURN       = 9'd360;

    // One restoring-division lane in flight
    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // Side information that rides along with the divider lanes
    typedef struct packed {
        sector_t    sector;
        logic       neg;
        logic       grey;
        logic [6:0] bright;
    } side_t;

    typedef struct packed {
        div_lane_t hue_lane;
        div_lane_t sat_lane;
        side_t     side;
    } div_item_t;

    // First front stage result
    typedef struct packed {
        logic [7:0] mx;
        logic [7:0] diff;
        logic [7:0] adelta;
        logic       neg;
        sector_t    sector;
    } front_item_t;

endpackage

// ===== rtl/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two stages: max/min/sector, then dividends and brightness.
// ----------------------------------------------------------------------------
module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_stall,
    input  rgb_t      up_item,
    output logic      dn_valid,
    input  logic      dn_stall,
    output div_item_t dn_item
);

    logic        s1_valid_reg;
    front_item_t s1_reg;
    front_item_t s1_next;
    logic        s1_stall;
    logic        s2_valid_reg;
    div_item_t   s2_reg;
    div_item_t   s2_next;
    logic        s2_stall;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [8:0]  delta;
    logic [14:0] hue_dvd;
    logic [14:0] sat_dvd;
    logic [14:0] val_x;
    logic [15:0] val_sum;

    // Stage 1: extremes, sector and signed channel difference
    always_comb
    begin
        mx = up_item.red;
        mn = up_item.red;
        if (up_item.green > mx) mx = up_item.green;
        if (up_item.blue > mx)  mx = up_item.blue;
        if (up_item.green < mn) mn = up_item.green;
        if (up_item.blue < mn)  mn = up_item.blue;

        if (up_item.red == mx)
        begin
            s1_next.sector = SECTOR_RED;
            delta = {1'b0, up_item.green} - {1'b0, up_item.blue};
        end
        else if (up_item.green == mx)
        begin
            s1_next.sector = SECTOR_GREEN;
            delta = {1'b0, up_item.blue} - {1'b0, up_item.red};
        end
        else
        begin
            s1_next.sector = SECTOR_BLUE;
            delta = {1'b0, up_item.red} - {1'b0, up_item.green};
        end

        s1_next.mx     = mx;
        s1_next.diff   = mx - mn;
        s1_next.neg    = delta[8];
        s1_next.adelta = delta[8] ? 8'(-delta) : delta[7:0];
    end

    // Stage 2: scale by constants; brightness via reciprocal of 255
    always_comb
    begin
        hue_dvd = ({7'd0, s1_reg.adelta} << 6) - ({7'd0, s1_reg.adelta} << 2);
        sat_dvd = ({7'd0, s1_reg.diff} << 6) + ({7'd0, s1_reg.diff} << 5)
                + ({7'd0, s1_reg.diff} << 2);
        val_x   = ({7'd0, s1_reg.mx} << 6) + ({7'd0, s1_reg.mx} << 5)
                + ({7'd0, s1_reg.mx} << 2);
        val_sum = {1'b0, val_x} + 16'd1 + {9'd0, val_x[14:8]};

        s2_next.hue_lane.rem = hue_dvd;
        s2_next.hue_lane.dvs = s1_reg.diff;
        s2_next.hue_lane.quo = '0;
        s2_next.sat_lane.rem = sat_dvd;
        s2_next.sat_lane.dvs = s1_reg.mx;
        s2_next.sat_lane.quo = '0;
        s2_next.side.sector  = s1_reg.sector;
        s2_next.side.neg     = s1_reg.neg;
        s2_next.side.grey    = (s1_reg.diff == 8'd0);
        s2_next.side.bright  = val_sum[14:8];
    end

    assign s2_stall = s2_valid_reg && dn_stall;
    assign s1_stall = s1_valid_reg && s2_stall;
    assign up_stall = s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_stall) s1_valid_reg <= up_valid;
            if (!s2_stall) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && up_valid)     s1_reg <= s1_next;
        if (!s2_stall && s1_valid_reg) s2_reg <= s2_next;
    end

    assign dn_valid = s2_valid_reg;
    assign dn_item  = s2_reg;

endmodule

// ===== rtl/rgbhsv_div_stage.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_div_stage
// Two restoring-division steps on the hue and saturation lanes.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage
    import rgbhsv_pkg::*;
#(
    parameter int SHIFT_HI = 7
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_stall,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_stall,
    output div_item_t dn_item
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic      stall;

    function automatic div_lane_t div_step(input div_lane_t lane, input int sh);
        logic [DVD_W:0] rem_x;
        logic [DVD_W:0] dvs_x;
        logic [DVD_W:0] trial;
        logic           ge;
        div_lane_t      res;
        rem_x = {1'b0, lane.rem};
        dvs_x = {{(DVD_W + 1 - DVS_W){1'b0}}, lane.dvs} << sh;
        trial = rem_x - dvs_x;
        ge    = (rem_x >= dvs_x);
        res   = lane;
        res.quo = {lane.quo[QUO_W-2:0], ge};
        if (ge) res.rem = trial[DVD_W-1:0];
        return res;
    endfunction

    always_comb
    begin
        item_next          = up_item;
        item_next.hue_lane = div_step(div_step(up_item.hue_lane, SHIFT_HI), SHIFT_HI - 1);
        item_next.sat_lane = div_step(div_step(up_item.sat_lane, SHIFT_HI), SHIFT_HI - 1);
    end

    assign stall    = valid_reg && dn_stall;
    assign up_stall = stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!stall && up_valid) item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ===== rtl/rgbhsv_back.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_back
// Hue assembly from sector, sign and quotient; output register.
// ----------------------------------------------------------------------------
module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_stall,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_stall,
    output hsv_t      dn_item
);

    logic       valid_reg;
    hsv_t       hsv_reg;
    hsv_t       hsv_next;
    logic       stall;
    logic [8:0] base;
    logic [8:0] qx;
    logic [8:0] adj;
    logic [8:0] hue_raw;

    always_comb
    begin
        unique case (up_item.side.sector)
            SECTOR_RED:   base = RED_BASE;
            SECTOR_GREEN: base = GREEN_BASE;
            SECTOR_BLUE:  base = BLUE_BASE;
            default:      base = RED_BASE;
        endcase

        qx  = {1'b0, up_item.hue_lane.quo};
        // floor of a negative ratio rounds away from zero on a remainder
        adj = qx + {8'd0, (up_item.hue_lane.rem != '0)};

        if (up_item.side.neg)
            hue_raw = base - adj;
        else
            hue_raw = base + qx;
        if (hue_raw >= TURN) hue_raw = hue_raw - TURN;

        hsv_next.hue        = up_item.side.grey ? 9'd0 : hue_raw;
        hsv_next.saturation = up_item.side.grey ? 7'd0 : up_item.sat_lane.quo[6:0];
        hsv_next.brightness = up_item.side.bright;
    end

    assign stall    = valid_reg && dn_stall;
    assign up_stall = stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!stall && up_valid) hsv_reg <= hsv_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = hsv_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (hsv_reg.hue < TURN))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (hsv_reg.saturation <= 7'd100 && hsv_reg.brightness <= 7'd100))
        else $error("percentage out of range");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && !stall && up_item.side.grey) |=> (hsv_reg.hue == 9'd0
            && hsv_reg.saturation == 7'd0))
        else $error("grey pixel with nonzero hue or saturation");

    a_hue_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && !up_item.side.grey) |-> (up_item.hue_lane.quo <= 8'd60))
        else $error("hue quotient beyond one sector");

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Pipelined conversion of 8-bit RGB pixels to integer HSV.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  pixel    | pixel_valid / pixel_stall  | rgb_t: red, green, blue
//  hsv      | hsv_valid / hsv_stall      | hsv_t: hue, saturation, brightness
//
//  One pixel enters per cycle while pixel_stall is low. Each pixel passes two
//  front stages, the 8-step restoring divider run two steps per stage over
//  four stages, and one output stage.
//  Reset clears only the valid bits; payload registers are not reset.
//  A stall holds only stages that carry a pixel, so bubbles collapse and the
//  input keeps taking pixels while the result waits, until every stage is full.
//
module rgb_to_hsv_pixel
    import rgbhsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pixel_valid,
    output logic pixel_stall,
    input  rgb_t pixel,
    output logic hsv_valid,
    input  logic hsv_stall,
    output hsv_t hsv
);

    localparam int NUM_DIV = 4;

    // Stage links: index 0 is the front output, NUM_DIV the divider output
    logic      link_valid [NUM_DIV+1];
    logic      link_stall [NUM_DIV+1];
    div_item_t link_item  [NUM_DIV+1];

    // Front: extremes and sector, then dividends and brightness
    rgbhsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_stall (pixel_stall),
        .up_item  (pixel),
        .dn_valid (link_valid[0]),
        .dn_stall (link_stall[0]),
        .dn_item  (link_item[0])
    );

    // Divider: each stage retires two quotient bits, most significant first
    for (genvar i = 0; i < NUM_DIV; i++)
    begin : g_div
        rgbhsv_div_stage #(
            .SHIFT_HI (2 * (NUM_DIV - i) - 1)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_stall (link_stall[i]),
            .up_item  (link_item[i]),
            .dn_valid (link_valid[i+1]),
            .dn_stall (link_stall[i+1]),
            .dn_item  (link_item[i+1])
        );
    end

    // Back: fold sign and sector into hue, drop hue and saturation for grey
    rgbhsv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[NUM_DIV]),
        .up_stall (link_stall[NUM_DIV]),
        .up_item  (link_item[NUM_DIV]),
        .dn_valid (hsv_valid),
        .dn_stall (hsv_stall),
        .dn_item  (hsv)
    );

endmodule
